### rtl/lrmt_pkg.sv
// ----------------------------------------------------------------------------
// lrmt_pkg
// Shared types, codes and arithmetic helpers for the lazy range-add /
// range-min tree.
// ----------------------------------------------------------------------------
package lrmt_pkg;

    localparam int DEF_LEAF_COUNT   = 16;
    localparam int MAX_TREE_LEAVES  = 31;   // active_leaves is 5 bits wide
    localparam int IDX_W            = 5;    // leaf span bounds inside the tree
    localparam int VAL_W            = 32;
    localparam int ACT_W            = 2;
    localparam int IN_DATA_W        = 40;
    localparam int OUT_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [IDX_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

    // configuration register index (paddr[2])
    localparam logic REG_ACTIVE_LEAVES = 1'b0;

    // actions
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd3;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
    localparam logic [OP_W-1:0] OP_RD0     = 5'd2;
    localparam logic [OP_W-1:0] OP_RD1     = 5'd3;
    localparam logic [OP_W-1:0] OP_RD2     = 5'd4;
    localparam logic [OP_W-1:0] OP_APPLY   = 5'd5;
    localparam logic [OP_W-1:0] OP_COVER   = 5'd6;
    localparam logic [OP_W-1:0] OP_WRK     = 5'd7;
    localparam logic [OP_W-1:0] OP_WRL     = 5'd8;
    localparam logic [OP_W-1:0] OP_WRR     = 5'd9;
    localparam logic [OP_W-1:0] OP_PUSH    = 5'd10;
    localparam logic [OP_W-1:0] OP_RIGHT   = 5'd11;
    localparam logic [OP_W-1:0] OP_POP     = 5'd12;
    localparam logic [OP_W-1:0] OP_POST_RD = 5'd13;
    localparam logic [OP_W-1:0] OP_POST_WR = 5'd14;
    localparam logic [OP_W-1:0] OP_LEAF_RD = 5'd15;
    localparam logic [OP_W-1:0] OP_LEAF_WR = 5'd16;
    localparam logic [OP_W-1:0] OP_FINISH  = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             is_leaf;
        logic             outside;
        logic             covered;
        logic             stack_empty;
        logic             top_right_done;
        logic             out_free;
    } dp_status_t;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
        begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] min_val(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

### rtl/lazy_range_add_min_tree_unit.sv
// ----------------------------------------------------------------------------
// lazy_range_add_min_tree_unit
// Range-minimum tree with lazy range-add over signed 32-bit leaves.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the action (write leaf,
//   build, range add, range min query), tdata the range bounds and operand.
//   Each request yields exactly one response on m_axis: the minimum (query) or
//   zero, with tuser flagging a query that covered no leaf.
//   The APB port holds active_leaves (reset 16); write it only while idle.
// Operation:
//   One request at a time. Build visits every node depth-first. Add and
//   query walk the tree depth-first too; the single write port of the
//   pending-mark store means a node's own mark and, for an inner node,
//   its two children's marks are written in turn.
// Reset:
//   Node minima and pending marks read as zero (per-entry valid bits cleared);
//   the leaf store is undefined until written.
// Backpressure:
//   A finished response waits in the output register; the next request is
//   still accepted and runs, holding only at its own completion until the
//   register frees.
// ----------------------------------------------------------------------------
module lazy_range_add_min_tree_unit #(
    parameter int LEAF_COUNT = lrmt_pkg::DEF_LEAF_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lrmt_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // range_low[3:0], range_high[7:4], operand_value[39:8]
    input  logic [lrmt_pkg::ACT_W-1:0]          s_axis_tuser,  // action[1:0]
    // response stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lrmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // result_value[31:0]
    output logic                                m_axis_tuser,  // range_empty[0]
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrmt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lrmt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lrmt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lrmt_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] active_reg;

    // configuration register; word index is paddr[2]
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_LEAVES)
        begin
            active_reg <= pwdata[IDX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_LEAVES) ? CFG_DATA_W'(active_reg) : '0;

    // sequencer
    lrmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tree stores and arithmetic
    lrmt_dp #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_user       (s_axis_tuser),
        .in_data       (s_axis_tdata),
        .active_leaves (active_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .out_user      (m_axis_tuser)
    );

endmodule

### rtl/lrmt_ctrl.sv
// ----------------------------------------------------------------------------
// lrmt_ctrl
// Sequencer for the tree walk: steps the datapath through node visits,
// child descents, returns and result delivery.
// ----------------------------------------------------------------------------
module lrmt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lrmt_pkg::dp_status_t  status,
    output lrmt_pkg::dp_cmd_t     cmd
);
    import lrmt_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] S_START   = 5'd1;
    localparam logic [ST_W-1:0] S_RD0     = 5'd2;
    localparam logic [ST_W-1:0] S_RD1     = 5'd3;
    localparam logic [ST_W-1:0] S_RD2     = 5'd4;
    localparam logic [ST_W-1:0] S_APPLY   = 5'd5;
    localparam logic [ST_W-1:0] S_COVER   = 5'd6;
    localparam logic [ST_W-1:0] S_WRK     = 5'd7;
    localparam logic [ST_W-1:0] S_WRL     = 5'd8;
    localparam logic [ST_W-1:0] S_WRR     = 5'd9;
    localparam logic [ST_W-1:0] S_DESC    = 5'd10;
    localparam logic [ST_W-1:0] S_RET     = 5'd11;
    localparam logic [ST_W-1:0] S_POST_RD = 5'd12;
    localparam logic [ST_W-1:0] S_POST_WR = 5'd13;
    localparam logic [ST_W-1:0] S_BVISIT  = 5'd14;
    localparam logic [ST_W-1:0] S_LEAF_WR = 5'd15;
    localparam logic [ST_W-1:0] S_DONE    = 5'd16;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (status.action)
                    ACT_WRITE: state_next = S_DONE;
                    ACT_BUILD: state_next = S_BVISIT;
                    default:   state_next = S_RD0;
                endcase
            end
            S_RD0:
            begin
                cmd.op     = OP_RD0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.op     = OP_RD2;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = S_COVER;
            end
            S_COVER:
            begin
                cmd.op     = OP_COVER;
                state_next = S_WRK;
            end
            S_WRK:
            begin
                cmd.op     = OP_WRK;
                state_next = status.is_leaf ? S_DESC : S_WRL;
            end
            S_WRL:
            begin
                cmd.op     = OP_WRL;
                state_next = S_WRR;
            end
            S_WRR:
            begin
                cmd.op     = OP_WRR;
                state_next = S_DESC;
            end
            S_DESC:
            begin
                if (status.outside || status.covered)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_RD0;
                end
            end
            S_RET:
            begin
                priority if (status.stack_empty)
                begin
                    state_next = S_DONE;
                end
                else if (!status.top_right_done)
                begin
                    cmd.op     = OP_RIGHT;
                    state_next = (status.action == ACT_BUILD) ? S_BVISIT : S_RD0;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = (status.action == ACT_QUERY) ? S_RET : S_POST_RD;
                end
            end
            S_POST_RD:
            begin
                cmd.op     = OP_POST_RD;
                state_next = S_POST_WR;
            end
            S_POST_WR:
            begin
                cmd.op     = OP_POST_WR;
                state_next = S_RET;
            end
            S_BVISIT:
            begin
                if (status.is_leaf)
                begin
                    cmd.op     = OP_LEAF_RD;
                    state_next = S_LEAF_WR;
                end
                else
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_BVISIT;
                end
            end
            S_LEAF_WR:
            begin
                cmd.op     = OP_LEAF_WR;
                state_next = S_RET;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/lrmt_dp.sv
// ----------------------------------------------------------------------------
// lrmt_dp
// Datapath: node and pending stores, leaf store, traversal stack,
// saturating arithmetic and the output register.
// ----------------------------------------------------------------------------
module lrmt_dp #(
    parameter int LEAF_COUNT = lrmt_pkg::DEF_LEAF_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lrmt_pkg::dp_cmd_t                  cmd,
    output lrmt_pkg::dp_status_t               status,
    input  logic [lrmt_pkg::ACT_W-1:0]         in_user,
    input  logic [lrmt_pkg::IN_DATA_W-1:0]     in_data,
    input  logic [lrmt_pkg::IDX_W-1:0]         active_leaves,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lrmt_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                               out_user
);
    import lrmt_pkg::*;

    localparam int TL         = (LEAF_COUNT < MAX_TREE_LEAVES) ? LEAF_COUNT
                                                               : MAX_TREE_LEAVES;
    localparam int NODE_SLOTS = 4 * TL;
    localparam int NODE_AW    = $clog2(NODE_SLOTS);
    localparam int LS_AW      = $clog2(TL);
    localparam int SD         = $clog2(TL);
    localparam int STK_AW     = (SD > 1) ? $clog2(SD) : 1;
    localparam int SP_W       = $clog2(SD + 1);

    // latched item
    logic [ACT_W-1:0]        act_reg;
    logic [3:0]              lo_reg;
    logic [3:0]              hi_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0]        last_reg;

    // current node
    logic [NODE_AW-1:0]      k_reg;
    logic [IDX_W-1:0]        s_reg;
    logic [IDX_W-1:0]        e_reg;
    logic [SP_W-1:0]         sp_reg;
    logic signed [VAL_W-1:0] acc_reg;

    // ancestor stack
    logic [NODE_AW-1:0]      stk_k  [SD];
    logic [IDX_W-1:0]        stk_s  [SD];
    logic [IDX_W-1:0]        stk_e  [SD];
    logic                    stk_ph [SD];

    // stores
    logic signed [VAL_W-1:0] nm_mem [NODE_SLOTS];
    logic signed [VAL_W-1:0] pa_mem [NODE_SLOTS];
    logic signed [VAL_W-1:0] ls_mem [TL];
    logic [NODE_SLOTS-1:0]   nv_reg;
    logic [NODE_SLOTS-1:0]   pv_reg;

    logic signed [VAL_W-1:0] nm_a_q, nm_b_q, pa_a_q, pa_b_q, ls_q;
    logic signed [VAL_W-1:0] pl_reg, nm1_reg, pl1_reg, pr1_reg;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_empty_reg;

    logic [NODE_AW-1:0]      k_l, k_r;
    logic [IDX_W:0]          mid_sum, top_mid_sum;
    logic [STK_AW-1:0]       tidx, pidx;
    logic [IDX_W-1:0]        lo_x, hi_x, n_clamp;

    logic                    nm_re_a, nm_re_b, nm_we, pa_re_a, pa_re_b, pa_we, ls_we;
    logic [NODE_AW-1:0]      nm_ra, nm_rb, nm_wa, pa_ra, pa_rb, pa_wa;
    logic signed [VAL_W-1:0] nm_wd, pa_wd;
    logic                    is_load, build_load;

    assign k_l         = {k_reg[NODE_AW-2:0], 1'b0};
    assign k_r         = {k_reg[NODE_AW-2:0], 1'b1};
    assign mid_sum     = {1'b0, s_reg} + {1'b0, e_reg};
    assign tidx        = STK_AW'(sp_reg - 1'b1);
    assign pidx        = STK_AW'(sp_reg);
    assign top_mid_sum = {1'b0, stk_s[tidx]} + {1'b0, stk_e[tidx]};
    assign lo_x        = {1'b0, lo_reg};
    assign hi_x        = {1'b0, hi_reg};
    assign is_load     = (cmd.op == OP_LOAD);
    assign build_load  = is_load && (in_user == ACT_BUILD);
    assign ls_we       = is_load && (in_user == ACT_WRITE) && (32'(in_data[3:0]) < TL);

    always_comb
    begin
        if (active_leaves == '0)
        begin
            n_clamp = IDX_W'(1);
        end
        else if (32'(active_leaves) > TL)
        begin
            n_clamp = IDX_W'(TL);
        end
        else
        begin
            n_clamp = active_leaves;
        end
    end

    // status
    assign status.action         = act_reg;
    assign status.is_leaf        = (s_reg == e_reg);
    assign status.outside        = (e_reg < lo_x) || (s_reg > hi_x);
    assign status.covered        = (s_reg >= lo_x) && (e_reg <= hi_x);
    assign status.stack_empty    = (sp_reg == '0);
    assign status.top_right_done = stk_ph[tidx];
    assign status.out_free       = !out_valid_reg || out_ready;

    // store port steering
    always_comb
    begin
        nm_re_a = 1'b0;  nm_re_b = 1'b0;  nm_we = 1'b0;
        pa_re_a = 1'b0;  pa_re_b = 1'b0;  pa_we = 1'b0;
        nm_ra   = k_reg; nm_rb   = k_r;   nm_wa = k_reg;
        pa_ra   = k_reg; pa_rb   = k_l;   pa_wa = k_reg;
        nm_wd   = nm1_reg;
        pa_wd   = '0;
        unique case (cmd.op)
            OP_RD0:
            begin
                nm_re_a = 1'b1;
                pa_re_a = 1'b1;
                pa_re_b = !status.is_leaf;
            end
            OP_RD1:
            begin
                pa_rb   = k_r;
                pa_re_b = !status.is_leaf;
            end
            OP_WRK:
            begin
                nm_we = 1'b1;
                pa_we = 1'b1;
            end
            OP_WRL:
            begin
                pa_we = 1'b1;
                pa_wa = k_l;
                pa_wd = pl1_reg;
            end
            OP_WRR:
            begin
                pa_we = 1'b1;
                pa_wa = k_r;
                pa_wd = pr1_reg;
            end
            OP_POST_RD:
            begin
                nm_ra   = k_l;
                nm_re_a = 1'b1;
                nm_re_b = 1'b1;
            end
            OP_POST_WR:
            begin
                nm_we = 1'b1;
                nm_wd = min_val(nm_a_q, nm_b_q);
            end
            OP_LEAF_WR:
            begin
                nm_we = 1'b1;
                nm_wd = ls_q;
            end
            default:
            begin
            end
        endcase
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[nm_wa] <= nm_wd;
        end
        if (pa_we)
        begin
            pa_mem[pa_wa] <= pa_wd;
        end
        if (ls_we)
        begin
            ls_mem[LS_AW'(in_data[3:0])] <= in_data[39:8];
        end
        if (nm_re_a)
        begin
            nm_a_q <= nv_reg[nm_ra] ? nm_mem[nm_ra] : '0;
        end
        if (nm_re_b)
        begin
            nm_b_q <= nv_reg[nm_rb] ? nm_mem[nm_rb] : '0;
        end
        if (pa_re_a)
        begin
            pa_a_q <= pv_reg[pa_ra] ? pa_mem[pa_ra] : '0;
        end
        if (pa_re_b)
        begin
            pa_b_q <= pv_reg[pa_rb] ? pa_mem[pa_rb] : '0;
        end
        if (cmd.op == OP_LEAF_RD)
        begin
            ls_q <= ls_mem[LS_AW'(s_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= '0;
            pv_reg <= '0;
        end
        else
        begin
            if (nm_we)
            begin
                nv_reg[nm_wa] <= 1'b1;
            end
            if (build_load)
            begin
                pv_reg <= '0;   // build drops every pending mark
            end
            else if (pa_we)
            begin
                pv_reg[pa_wa] <= 1'b1;
            end
        end
    end

    // item, node arithmetic, stack
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                act_reg  <= in_user;
                lo_reg   <= in_data[3:0];
                hi_reg   <= in_data[7:4];
                val_reg  <= in_data[39:8];
                last_reg <= n_clamp - 1'b1;
                k_reg    <= NODE_AW'(1);
                s_reg    <= '0;
                e_reg    <= n_clamp - 1'b1;
                acc_reg  <= VAL_MAX;
            end
            OP_RD1:
            begin
                pl_reg <= pa_b_q;
            end
            OP_APPLY:
            begin
                nm1_reg <= sat_add(nm_a_q, pa_a_q);
                pl1_reg <= sat_add(pl_reg, pa_a_q);
                pr1_reg <= sat_add(pa_b_q, pa_a_q);
            end
            OP_COVER:
            begin
                if (status.covered && act_reg == ACT_ADD)
                begin
                    nm1_reg <= sat_add(nm1_reg, val_reg);
                    pl1_reg <= sat_add(pl1_reg, val_reg);
                    pr1_reg <= sat_add(pr1_reg, val_reg);
                end
                if (status.covered && act_reg == ACT_QUERY)
                begin
                    acc_reg <= min_val(acc_reg, nm1_reg);
                end
            end
            OP_PUSH:
            begin
                stk_k[pidx]  <= k_reg;
                stk_s[pidx]  <= s_reg;
                stk_e[pidx]  <= e_reg;
                stk_ph[pidx] <= 1'b0;
                k_reg        <= k_l;
                e_reg        <= mid_sum[IDX_W:1];
            end
            OP_RIGHT:
            begin
                stk_ph[tidx] <= 1'b1;
                k_reg        <= {stk_k[tidx][NODE_AW-2:0], 1'b1};
                s_reg        <= top_mid_sum[IDX_W:1] + 1'b1;
                e_reg        <= stk_e[tidx];
            end
            OP_POP:
            begin
                k_reg <= stk_k[tidx];
                s_reg <= stk_s[tidx];
                e_reg <= stk_e[tidx];
            end
            default:
            begin
            end
        endcase
    end

    // control state: stack pointer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD: sp_reg <= '0;
                OP_PUSH: sp_reg <= sp_reg + 1'b1;
                OP_POP:  sp_reg <= sp_reg - 1'b1;
                default: sp_reg <= sp_reg;
            endcase
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            if (act_reg == ACT_QUERY)
            begin
                out_value_reg <= acc_reg;
                out_empty_reg <= (lo_reg > hi_reg) || (lo_x > last_reg);
            end
            else
            begin
                out_value_reg <= '0;
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_value_reg;
    assign out_user  = out_empty_reg;

    // checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUSH) |-> (32'(sp_reg) < SD))
        else $error("stack overflow on descent");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_POP || cmd.op == OP_RIGHT) |-> (sp_reg != '0))
        else $error("stack access while empty");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |=> out_valid_reg)
        else $error("finished request did not reach output");

    a_child_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WRL || cmd.op == OP_WRR) |-> (s_reg != e_reg))
        else $error("child mark written below a leaf");

endmodule
